[sv/upd_pkg.sv]
package upd_pkg;

  localparam int BYTE_W = 8;
  localparam int MAX_RES = 3;

  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  // Up to three decoded bytes caused by one input item, oldest in slot 0.
  typedef struct packed {
    logic [1:0]               cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
    logic                     last;
  } burst_t;

endpackage

[sv/upd_ifs.sv]
interface upd_in_if;
  import upd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  import upd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface upd_cfg_if;
  logic valid;
  logic ready;
  logic plus_as_space;
  modport source (output valid, output plus_as_space, input ready);
  modport sink (input valid, input plus_as_space, output ready);
endinterface

[sv/upd_decode.sv]
module upd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  upd_pkg::byte_t  in_byte,
  input  logic            in_last,
  input  logic            plus_as_space,
  output upd_pkg::burst_t dec,
  output logic [1:0]      phase
);
  import upd_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  byte_t      held_r, held_nxt;

  // Returns the digit value in the low four bits; bit 4 is set for a non-hex character.
  function automatic logic [4:0] hex_value(input byte_t c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

  logic [4:0] hv;
  logic [4:0] held_hv;
  logic       is_hex;
  logic       p_emit;
  logic       p_start;
  byte_t      p_byte;

  assign hv      = hex_value(in_byte);
  assign held_hv = hex_value(held_r);
  assign is_hex  = !hv[4];

  // Handling of the current byte as if no escape were pending.
  always_comb begin
    p_emit  = 1'b1;
    p_start = 1'b0;
    p_byte  = in_byte;
    if (in_byte == CH_PERCENT) begin
      if (!in_last) begin
        p_emit  = 1'b0;
        p_start = 1'b1;
      end
    end else if (in_byte == CH_PLUS && plus_as_space) begin
      p_byte = CH_SPACE;
    end
  end

  always_comb begin
    logic [1:0]                     n;
    logic [MAX_RES-1:0][BYTE_W-1:0] b;
    n         = 2'd0;
    b         = '0;
    phase_nxt = PH_IDLE;
    held_nxt  = '0;
    case (phase_r)
      PH_PCT: begin
        if (is_hex) begin
          if (in_last) begin
            b[n] = CH_PERCENT; n = n + 2'd1;
            b[n] = in_byte;    n = n + 2'd1;
          end else begin
            held_nxt  = in_byte;
            phase_nxt = PH_DIGIT;
          end
        end else begin
          b[n] = CH_PERCENT; n = n + 2'd1;
          if (p_emit) begin
            b[n] = p_byte; n = n + 2'd1;
          end
          if (p_start) phase_nxt = PH_PCT;
        end
      end
      PH_DIGIT: begin
        if (is_hex) begin
          b[n] = {held_hv[3:0], hv[3:0]}; n = n + 2'd1;
        end else begin
          b[n] = CH_PERCENT; n = n + 2'd1;
          b[n] = held_r;     n = n + 2'd1;
          if (p_emit) begin
            b[n] = p_byte; n = n + 2'd1;
          end
          if (p_start) phase_nxt = PH_PCT;
        end
      end
      default: begin
        if (p_emit) begin
          b[n] = p_byte; n = n + 2'd1;
        end
        if (p_start) phase_nxt = PH_PCT;
      end
    endcase
    if (in_last) begin
      phase_nxt = PH_IDLE;
      held_nxt  = '0;
    end
    dec.cnt   = n;
    dec.bytes = b;
    dec.last  = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  assign phase = phase_r;

endmodule

[sv/upd_burst.sv]
module upd_burst (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  upd_pkg::burst_t dec,
  input  logic            out_ready,
  output logic            in_ready,
  output logic            out_valid,
  output upd_pkg::byte_t  out_byte,
  output logic            out_last
);
  import upd_pkg::*;

  burst_t buf_r, buf_nxt;
  logic   out_fire;

  assign out_valid = (buf_r.cnt != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign out_byte  = buf_r.bytes[0];
  assign out_last  = buf_r.last && (buf_r.cnt == 2'd1);

  // A new item may load while the final byte of the previous one leaves.
  assign in_ready = (buf_r.cnt == 2'd0) || ((buf_r.cnt == 2'd1) && out_ready);

  always_comb begin
    buf_nxt = buf_r;
    if (out_fire) begin
      buf_nxt.bytes = {{BYTE_W{1'b0}}, buf_r.bytes[MAX_RES-1:1]};
      buf_nxt.cnt   = buf_r.cnt - 2'd1;
    end
    if (in_fire && dec.cnt != 2'd0) begin
      buf_nxt = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r.cnt <= 2'd0;
    end else begin
      buf_r.cnt <= buf_nxt.cnt;
    end
    buf_r.bytes <= buf_nxt.bytes;
    buf_r.last  <= buf_nxt.last;
  end

endmodule

[sv/url_percent_decoder.sv]
// URL percent decoder: one encoded character per item, zero to three decoded bytes out.
// The first result of an item is registered and valid in the cycle after its acceptance.
// Throughput: one item per cycle while each item yields at most one byte and out is ready;
// a longer item holds the output register, stalling input, until all its bytes have left.
// Reset (synchronous, rst_n low): no escape pending, output empty, plus_as_space = 1.
module url_percent_decoder (
  input logic      clk,
  input logic      rst_n,
  upd_in_if.sink   in_ch,
  upd_out_if.source out_ch,
  upd_cfg_if.sink  cfg_ch
);
  import upd_pkg::*;

  logic       plus_as_space_r;
  logic       in_ready;
  logic       in_fire;
  logic [1:0] phase;
  burst_t     dec;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_as_space_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      plus_as_space_r <= cfg_ch.plus_as_space;
    end
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  upd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_byte       (in_ch.in_byte),
    .in_last       (in_ch.in_last),
    .plus_as_space (plus_as_space_r),
    .dec           (dec),
    .phase         (phase)
  );

  upd_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .dec       (dec),
    .out_ready (out_ch.ready),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

  // The end of a string always leaves the escape state idle.
  a_last_clears_escape: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.in_last |=> phase == PH_IDLE)
    else $error("escape still pending after last item");

  // The last item of a string always yields at least one byte to carry the mark.
  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.in_last |-> dec.cnt != 2'd0)
    else $error("last item produced no result");

  // A marked result is followed by a fresh string: no escape is left pending.
  a_out_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_last |-> phase == PH_IDLE)
    else $error("escape pending while last byte is shown");

endmodule
